/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue.
// Item layouts, request modes, result status codes and the controller's
// command to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default number of entries held by the queue.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Widths fixed by the item layouts.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [VALUE_W-1:0] head_value;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic  exec;
    mode_t op;
  } cmd_t;

endpackage

/* rtl/core/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: request controller.
// Tracks whether a result item is held in the output register, decides when
// a request item is taken and tells the datapath to execute it.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output spq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_HOLD  = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new item may enter whenever the output register is free or is emptied
  // in the same cycle.
  assign in_stall  = (state_r == S_HOLD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == S_HOLD);

  assign cmd.exec = accept;
  assign cmd.op   = spq_pkg::mode_t'(in_mode);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EMPTY: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end else if (!out_stall) begin
          state_nxt = S_EMPTY;
        end
      end
      default: begin
        state_nxt = S_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/spq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dpath: queue storage and result datapath.
// A row of compare-and-shift cells keeps the entries in descending order,
// with the fill count and the registered result item alongside.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  spq_pkg::cmd_t                          cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0]     in_value,
  output spq_pkg::out_item_t                     out_item
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  logic signed [spq_pkg::VALUE_W-1:0] entries_r   [QUEUE_DEPTH];
  logic signed [spq_pkg::VALUE_W-1:0] entries_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]             take;
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   count_nxt;
  logic [CNT_W-1:0]                   count_m1;
  logic [CNT_W+spq_pkg::COUNT_W-1:0]  count_ext;
  logic [IDX_W-1:0]                   tail_idx;
  logic                               full;
  logic                               empty;
  logic                               ins_go;
  spq_pkg::out_item_t                 out_r;
  spq_pkg::out_item_t                 out_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign ins_go   = cmd.exec && (cmd.op == spq_pkg::MODE_INSERT) && !full;
  assign count_m1 = count_r - CNT_W'(1);
  assign tail_idx = count_m1[IDX_W-1:0];

  // Each cell decides whether the new value belongs at or above it. Slots past
  // the fill count always take, so the take pattern runs false then true.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign take[i] = (CNT_W'(i) < count_r) ? (in_value >= entries_r[i]) : 1'b1;

    if (i == 0) begin : g_head
      always_comb begin
        entries_nxt[i] = entries_r[i];
        if (ins_go && take[i]) begin
          entries_nxt[i] = in_value;
        end
      end
    end else begin : g_body
      // The first taking cell loads the value; the ones below shift down.
      always_comb begin
        entries_nxt[i] = entries_r[i];
        if (ins_go && take[i]) begin
          entries_nxt[i] = take[i-1] ? entries_r[i-1] : in_value;
        end
      end
    end

    always_ff @(posedge clk) begin
      entries_r[i] <= entries_nxt[i];
    end
  end

  // Fill count and result item.
  always_comb begin
    count_nxt             = count_r;
    out_nxt.removed_value = '0;
    out_nxt.status        = spq_pkg::STATUS_OK;
    unique case (cmd.op)
      spq_pkg::MODE_INSERT: begin
        if (full) begin
          out_nxt.status = spq_pkg::STATUS_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      spq_pkg::MODE_PEEK: begin
        if (empty) begin
          out_nxt.status = spq_pkg::STATUS_EMPTY;
        end
      end
      spq_pkg::MODE_REMOVE: begin
        if (empty) begin
          out_nxt.status = spq_pkg::STATUS_EMPTY;
        end else begin
          out_nxt.removed_value = entries_r[tail_idx];
          count_nxt             = count_m1;
        end
      end
      spq_pkg::MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    count_ext           = {{spq_pkg::COUNT_W{1'b0}}, count_nxt};
    out_nxt.entry_count = count_ext[spq_pkg::COUNT_W-1:0];
    out_nxt.head_value  = (count_nxt != '0) ? entries_nxt[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // The result register needs no reset; its valid lives in the controller.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

/* rtl/core/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in descending order.
// Insert, peek head, remove tail and clear requests, one result per request.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH signed 32-bit values, largest at the head.
// Every request item gives exactly one result item, registered in the cycle
// after the request is taken; with the output side not stalling, a request is
// taken every cycle. That rate is set by the row of compare-and-shift cells,
// which finds the insertion place and shifts the lower entries combinationally,
// and by the output register, which frees the input side as the result leaves.
// Inserting into a full queue, or peeking or removing from an empty one,
// reports an error status and leaves the contents unchanged. No clearing pass
// is needed after reset.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);

  spq_pkg::cmd_t cmd;

  // Handshake control.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Storage and result datapath.
  spq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_data.value),
    .out_item (out_data)
  );

endmodule
